// File: hw/rtl/mwsal_pkg.sv
// types of the shortest window sum block; cmd_t and status_t are shared with the datapath
`timescale 1ns / 1ps

package mwsal_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic push;
        logic mark_over;
        logic rd_oldest;
        logic pop;
        logic upd_best;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic pop_ok;
        logic last;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/mwsal_ctrl.sv
// controller state machine for the shortest window sum block
`timescale 1ns / 1ps

module mwsal_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mwsal_pkg::status_t status,
    output mwsal_pkg::cmd_t    cmd
);
    import mwsal_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                accept  = s_valid;
                if (accept) begin
                    cmd.capture = 1'b1;
                    if (status.full) begin
                        cmd.mark_over = 1'b1;
                        state_next    = ST_EMIT;
                    end else begin
                        cmd.push   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_oldest = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.pop_ok) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_READ;
                end else begin
                    cmd.upd_best = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // non-last words leave here at once
                if (!status.last) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/mwsal_dp.sv
// datapath of the shortest window sum block: window memory, sums, counters, result register
`timescale 1ns / 1ps

module mwsal_dp #(
    parameter int MAX_LEN    = 1024,
    parameter int ELEM_WIDTH = 16,
    parameter int IDX_W      = $clog2(MAX_LEN),
    parameter int CNT_W      = $clog2(MAX_LEN + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [ELEM_WIDTH-1:0] s_element,
    input  logic                  s_is_last,
    input  logic                  cfg_valid,
    input  logic [31:0]           cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CNT_W-1:0]      m_min_length,
    output logic                  m_too_long,
    input  mwsal_pkg::cmd_t       cmd,
    output mwsal_pkg::status_t    status
);
    import mwsal_pkg::*;

    localparam int SUM_W = ELEM_WIDTH + CNT_W;
    localparam int CMP_W = (SUM_W > 32) ? SUM_W : 32;

    logic [ELEM_WIDTH-1:0] mem [MAX_LEN];
    logic [ELEM_WIDTH-1:0] rdata_reg;

    logic [31:0]      target_reg;
    logic [IDX_W-1:0] oldest_reg,  oldest_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [SUM_W-1:0] sum_reg,     sum_next;
    logic [CNT_W-1:0] best_reg,    best_next;
    logic [CNT_W-1:0] seen_reg,    seen_next;
    logic             over_reg,    over_next;
    logic             last_reg;
    logic             m_valid_reg;
    logic [CNT_W-1:0] min_len_reg;
    logic             too_long_reg;

    logic [IDX_W:0]   slot_wide;
    logic [IDX_W-1:0] slot;
    logic [SUM_W-1:0] sum_less;
    logic             less_meets;
    logic             sum_meets;

    // write slot is oldest + count, wrapped once
    always_comb begin
        slot_wide = (IDX_W + 1)'(oldest_reg) + (IDX_W + 1)'(count_reg);
        if (slot_wide >= (IDX_W + 1)'(MAX_LEN)) begin
            slot_wide = slot_wide - (IDX_W + 1)'(MAX_LEN);
        end
        slot = slot_wide[IDX_W-1:0];
    end

    assign sum_less   = sum_reg - SUM_W'(rdata_reg);
    assign less_meets = CMP_W'(sum_less) >= CMP_W'(target_reg);
    assign sum_meets  = CMP_W'(sum_reg) >= CMP_W'(target_reg);

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[slot] <= s_element;
        end
        if (cmd.rd_oldest) begin
            rdata_reg <= mem[oldest_reg];
        end
    end

    always_comb begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        best_next   = best_reg;
        seen_next   = seen_reg;
        over_next   = over_reg;
        if (cmd.push) begin
            seen_next  = seen_reg + CNT_W'(1);
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(s_element);
        end
        if (cmd.mark_over) begin
            over_next = 1'b1;
        end
        if (cmd.pop) begin
            sum_next   = sum_less;
            count_next = count_reg - CNT_W'(1);
            if (oldest_reg == IDX_W'(MAX_LEN - 1)) begin
                oldest_next = '0;
            end else begin
                oldest_next = oldest_reg + IDX_W'(1);
            end
        end
        if (cmd.upd_best && sum_meets &&
            (best_reg == '0 || count_reg < best_reg)) begin
            best_next = count_reg;
        end
        if (cmd.emit) begin
            oldest_next = '0;
            count_next  = '0;
            sum_next    = '0;
            best_next   = '0;
            seen_next   = '0;
            over_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= 32'd1;
            oldest_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            best_reg    <= '0;
            seen_reg    <= '0;
            over_reg    <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                target_reg <= cfg_data;
            end
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            best_reg   <= best_next;
            seen_reg   <= seen_next;
            over_reg   <= over_next;
            if (cmd.capture) begin
                last_reg <= s_is_last;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            min_len_reg  <= best_reg;
            too_long_reg <= over_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_min_length = min_len_reg;
    assign m_too_long   = too_long_reg;

    assign status.full     = (seen_reg == CNT_W'(MAX_LEN));
    assign status.pop_ok   = (count_reg > CNT_W'(1)) && less_meets;
    assign status.last     = last_reg;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// File: hw/rtl/min_window_sum_at_least.sv
// top level of the shortest window sum block
`timescale 1ns / 1ps

// Finds the length of the shortest run of consecutive words whose sum reaches
// target_sum, over a sequence closed by a word with is_last set. The result
// word (min_length, 0 when no run qualifies, and too_long) is given once per
// sequence. An element passes through accept, memory read, compare and finish,
// with a further memory read and compare for every older element dropped from
// the window, since each drop waits on a registered read of the window memory;
// every element is dropped at most once. A new element is taken only after the
// previous one has finished. A last word loads the result register in its
// finishing cycle, and waits there while an earlier result is still untaken;
// the result word shows on the next cycle. Words beyond MAX_LEN in one sequence
// pass only through accept and finish and are discarded. target_sum resets to 1
// and is written through the cfg channel, which is always ready.
module min_window_sum_at_least #(
    parameter int MAX_LEN    = 1024,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ELEM_WIDTH-1:0]          s_element,
    input  logic                           s_is_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [$clog2(MAX_LEN + 1)-1:0] m_min_length,
    output logic                           m_too_long,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [31:0]                    cfg_data
);
    import mwsal_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mwsal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mwsal_dp #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_element    (s_element),
        .s_is_last    (s_is_last),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_min_length (m_min_length),
        .m_too_long   (m_too_long),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
